// ----- rtl/core/mdhl_pkg.sv -----
`default_nettype none

package mdhl_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned DwordW = 64;
	localparam int unsigned IterCnt = 32;
	localparam int unsigned CntW = $clog2(IterCnt);

	typedef enum logic [2:0] {
		OP_MULT  = 3'd0,
		OP_DIV   = 3'd1,
		OP_DIVU  = 3'd2,
		OP_MFLO  = 3'd3,
		OP_MFHI  = 3'd4,
		OP_MULT1 = 3'd5,
		OP_DIVU1 = 3'd6,
		OP_MFLO1 = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FIN
	} state_t;

	// Sequencer controls for the shared add/subtract unit
	typedef struct packed {
		logic load;
		logic step;
		logic is_mul;
	} core_ctrl_t;

	function automatic logic [DwordW-1:0] sext32(input logic [WordW-1:0] v);
		sext32 = {{(DwordW - WordW){v[WordW-1]}}, v};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mdhl_core.sv -----
`default_nettype none

module mdhl_core
	import mdhl_pkg::*;
(
	input  wire logic             clk,
	input  wire core_ctrl_t       ctrl,
	input  wire logic [WordW-1:0] load_mcand,
	input  wire logic [WordW-1:0] load_lo,
	output logic      [WordW-1:0] hi,
	output logic      [WordW-1:0] lo
);

	logic [WordW-1:0] hi_q;
	logic [WordW-1:0] lo_q;
	logic [WordW-1:0] mcand_q;
	logic [WordW:0]   a_op;
	logic [WordW:0]   b_op;
	logic             cin;
	logic [WordW+1:0] sum;

	// One adder: shift-add for multiply, trial subtract for restoring divide
	always_comb begin
		if (ctrl.is_mul) begin
			a_op = {1'b0, hi_q};
			b_op = lo_q[0] ? {1'b0, mcand_q} : '0;
			cin  = 1'b0;
		end else begin
			a_op = {hi_q, lo_q[WordW-1]};
			b_op = ~{1'b0, mcand_q};
			cin  = 1'b1;
		end
		sum = {1'b0, a_op} + {1'b0, b_op} + {{(WordW + 1){1'b0}}, cin};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mcand_q <= load_mcand;
			lo_q    <= load_lo;
			hi_q    <= '0;
		end else if (ctrl.step) begin
			if (ctrl.is_mul) begin
				hi_q <= sum[WordW:1];
				lo_q <= {sum[0], lo_q[WordW-1:1]};
			end else if (sum[WordW+1]) begin
				// no borrow: divisor fits
				hi_q <= sum[WordW-1:0];
				lo_q <= {lo_q[WordW-2:0], 1'b1};
			end else begin
				hi_q <= a_op[WordW-1:0];
				lo_q <= {lo_q[WordW-2:0], 1'b0};
			end
		end
	end

	assign hi = hi_q;
	assign lo = lo_q;

endmodule

`default_nettype wire

// ----- rtl/core/multiply_divide_hi_lo_unit.sv -----
// Channel | Direction | Handshake           | Beat fields
// input   | in        | in_valid, in_stall   | op, rs_value, rt_value
// output  | out       | out_valid, out_stall | rd_value, rd_write
//
// mult, mult1, div, divu, divu1: load, then 32 passes through the one shared
// 33-bit adder, then a sign fix-up. mflo, mfhi, mflo1 skip the adder loop and
// go straight to the fix-up. One instruction is in flight at a time.
// arst_n clears both lo/hi pairs and the control state.
// A result held by out_stall keeps the unit in its fix-up state until taken.
`default_nettype none

module multiply_divide_hi_lo_unit
	import mdhl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        op,
	input  wire logic [WordW-1:0]  rs_value,
	input  wire logic [WordW-1:0]  rt_value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [DwordW-1:0] rd_value,
	output logic                   rd_write
);

	state_t            state_q, state_d;
	logic [CntW-1:0]   cnt_q;
	op_t               op_q;
	logic              neg_q_q;
	logic              neg_r_q;
	logic [DwordW-1:0] lo_zero_q, hi_zero_q, lo_one_q, hi_one_q;
	logic              out_valid_q;
	logic [DwordW-1:0] rd_value_q;
	logic              rd_write_q;

	core_ctrl_t        ctrl;
	logic [WordW-1:0]  core_hi, core_lo;
	logic              accept;
	logic              finish;
	op_t               in_op;
	logic              in_signed, in_mul, in_arith;
	logic              neg_a, neg_b;
	logic [WordW-1:0]  mag_a, mag_b;

	logic [DwordW-1:0] prod;
	logic [WordW-1:0]  quo, rem;
	logic [DwordW-1:0] new_lo, new_hi, res_val;
	logic              res_wr, wr_pair0, wr_pair1;

	assign in_op  = op_t'(op);
	assign accept = in_valid && !in_stall;

	always_comb begin
		in_mul    = (in_op == OP_MULT) || (in_op == OP_MULT1);
		in_signed = in_mul || (in_op == OP_DIV);
		in_arith  = in_mul || (in_op == OP_DIV) || (in_op == OP_DIVU) || (in_op == OP_DIVU1);
		neg_a     = in_signed && rs_value[WordW-1];
		neg_b     = in_signed && rt_value[WordW-1];
		mag_a     = neg_a ? (~rs_value + 1'b1) : rs_value;
		mag_b     = neg_b ? (~rt_value + 1'b1) : rt_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		finish      = 1'b0;
		ctrl.load   = 1'b0;
		ctrl.step   = 1'b0;
		ctrl.is_mul = (op_q == OP_MULT) || (op_q == OP_MULT1);
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				ctrl.load = in_valid;
				if (in_valid) begin
					state_d = in_arith ? ST_CALC : ST_FIN;
				end
			end
			ST_CALC: begin
				ctrl.step = 1'b1;
				if (cnt_q == CntW'(IterCnt - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	mdhl_core u_core (
		.clk        (clk),
		.ctrl       (ctrl),
		.load_mcand (in_mul ? mag_a : mag_b),
		.load_lo    (in_mul ? mag_b : mag_a),
		.hi         (core_hi),
		.lo         (core_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q  <= OP_MULT;
		end else if (accept) begin
			cnt_q <= '0;
			op_q  <= in_op;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q_q <= neg_a ^ neg_b;
			neg_r_q <= neg_a;
		end
	end

	// Sign fix-up; divide by zero falls out of the restoring loop as is
	always_comb begin
		prod     = neg_q_q ? (~{core_hi, core_lo} + 1'b1) : {core_hi, core_lo};
		quo      = neg_q_q ? (~core_lo + 1'b1) : core_lo;
		rem      = neg_r_q ? (~core_hi + 1'b1) : core_hi;
		new_lo   = '0;
		new_hi   = '0;
		res_val  = '0;
		res_wr   = 1'b0;
		wr_pair0 = 1'b0;
		wr_pair1 = 1'b0;
		unique case (op_q)
			OP_MULT, OP_MULT1: begin
				new_lo   = sext32(prod[WordW-1:0]);
				new_hi   = sext32(prod[DwordW-1:WordW]);
				res_val  = new_lo;
				res_wr   = 1'b1;
				wr_pair0 = (op_q == OP_MULT);
				wr_pair1 = (op_q == OP_MULT1);
			end
			OP_DIV, OP_DIVU, OP_DIVU1: begin
				new_lo   = sext32(quo);
				new_hi   = sext32(rem);
				wr_pair0 = (op_q != OP_DIVU1);
				wr_pair1 = (op_q == OP_DIVU1);
			end
			OP_MFLO: begin
				res_val = lo_zero_q;
				res_wr  = 1'b1;
			end
			OP_MFHI: begin
				res_val = hi_zero_q;
				res_wr  = 1'b1;
			end
			OP_MFLO1: begin
				res_val = lo_one_q;
				res_wr  = 1'b1;
			end
			default: begin
				res_val = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_zero_q <= '0;
			hi_zero_q <= '0;
			lo_one_q  <= '0;
			hi_one_q  <= '0;
		end else if (finish) begin
			if (wr_pair0) begin
				lo_zero_q <= new_lo;
				hi_zero_q <= new_hi;
			end
			if (wr_pair1) begin
				lo_one_q <= new_lo;
				hi_one_q <= new_hi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rd_value_q <= res_val;
			rd_write_q <= res_wr;
		end
	end

	assign out_valid = out_valid_q;
	assign rd_value  = rd_value_q;
	assign rd_write  = rd_write_q;

endmodule

`default_nettype wire

// ----- rtl/core/mdhl_checker.sv -----
`default_nettype none

module mdhl_checker
	import mdhl_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [DwordW-1:0] rd_value,
	input wire logic              rd_write
);

	// held beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rd_value) && $stable(rd_write))
		else $error("output beat changed while stalled");

	a_out_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// one instruction in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on back-to-back cycles");

	// divides return no rd data
	a_nowr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rd_write |-> rd_value == '0)
		else $error("nonzero rd_value without rd_write");

	// a new beat needs the unit busy (in_stall high) just before it rises
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an instruction in flight");

endmodule

bind multiply_divide_hi_lo_unit mdhl_checker u_mdhl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.rd_value  (rd_value),
	.rd_write  (rd_write)
);

`default_nettype wire

// ----- dv/mdhl_rd_checker.sv -----
`timescale 1ns / 1ps

module mdhl_rd_checker
	import mdhl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [2:0]        op,
	input  wire logic [WordW-1:0]  rs_value,
	input  wire logic [WordW-1:0]  rt_value,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [DwordW-1:0] rd_value,
	input  wire logic              rd_write,
	output int                     error_count,
	output int                     pending_count,
	output int                     checked_count
);

	localparam logic [DwordW-1:0] ALL_ONES = '1;
	localparam logic [WordW-1:0]  MIN_WORD = 32'h8000_0000;
	localparam logic [WordW-1:0]  NEG_ONE  = 32'hFFFF_FFFF;

	typedef struct {
		op_t               code;
		logic [DwordW-1:0] value;
		logic              wr;
	} rd_beat_t;

	rd_beat_t          rd_expected[$];
	logic [DwordW-1:0] lo0 = '0;
	logic [DwordW-1:0] hi0 = '0;
	logic [DwordW-1:0] lo1 = '0;
	logic [DwordW-1:0] hi1 = '0;
	int                errors = 0;
	int                checked = 0;

	function automatic logic [DwordW-1:0] widen(input logic [WordW-1:0] w);
		return {{(DwordW - WordW){w[WordW-1]}}, w};
	endfunction

	// all pair helpers return {hi, lo}
	function automatic logic [2*DwordW-1:0] product_pair(input logic [WordW-1:0] a,
			input logic [WordW-1:0] b);
		logic signed [DwordW-1:0] p;
		p = $signed(widen(a)) * $signed(widen(b));
		return {widen(p[2*WordW-1:WordW]), widen(p[WordW-1:0])};
	endfunction

	function automatic logic [2*DwordW-1:0] udiv_pair(input logic [WordW-1:0] a,
			input logic [WordW-1:0] b);
		if (b == '0)
			return {widen(a), ALL_ONES};
		return {widen(a % b), widen(a / b)};
	endfunction

	function automatic logic [2*DwordW-1:0] sdiv_pair(input logic [WordW-1:0] a,
			input logic [WordW-1:0] b);
		logic [WordW-1:0] ma, mb, q, r;
		if (b == '0)
			return {widen(a), a[WordW-1] ? 64'd1 : ALL_ONES};
		if (a == MIN_WORD && b == NEG_ONE)
			return {64'd0, widen(MIN_WORD)};
		ma = a[WordW-1] ? -a : a;
		mb = b[WordW-1] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		// truncating: remainder follows the dividend
		if (a[WordW-1] ^ b[WordW-1])
			q = -q;
		if (a[WordW-1])
			r = -r;
		return {widen(r), widen(q)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rd_beat_t head;
		rd_beat_t next;
		if (!arst_n) begin
			lo0 = '0;
			hi0 = '0;
			lo1 = '0;
			hi1 = '0;
			rd_expected.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (rd_expected.size() == 0) begin
					errors++;
					$display("%0t: rd beat with nothing expected: value=%h write=%b",
						$time, rd_value, rd_write);
				end else begin
					head = rd_expected.pop_front();
					checked++;
					if (rd_value !== head.value) begin
						errors++;
						$display("%0t: %s rd_value expected %h actual %h",
							$time, head.code.name(), head.value, rd_value);
					end
					if (rd_write !== head.wr) begin
						errors++;
						$display("%0t: %s rd_write expected %b actual %b",
							$time, head.code.name(), head.wr, rd_write);
					end
				end
			end
			if (in_valid && !in_stall) begin
				next.code = op_t'(op);
				next.value = '0;
				next.wr = 1'b0;
				case (next.code)
					OP_MULT: begin
						{hi0, lo0} = product_pair(rs_value, rt_value);
						next.value = lo0;
						next.wr = 1'b1;
					end
					OP_DIV: {hi0, lo0} = sdiv_pair(rs_value, rt_value);
					OP_DIVU: {hi0, lo0} = udiv_pair(rs_value, rt_value);
					OP_MFLO: begin
						next.value = lo0;
						next.wr = 1'b1;
					end
					OP_MFHI: begin
						next.value = hi0;
						next.wr = 1'b1;
					end
					OP_MULT1: begin
						{hi1, lo1} = product_pair(rs_value, rt_value);
						next.value = lo1;
						next.wr = 1'b1;
					end
					OP_DIVU1: {hi1, lo1} = udiv_pair(rs_value, rt_value);
					OP_MFLO1: begin
						next.value = lo1;
						next.wr = 1'b1;
					end
				endcase
				rd_expected.push_back(next);
			end
		end
		error_count <= errors;
		pending_count <= rd_expected.size();
		checked_count <= checked;
	end

endmodule

// ----- dv/multiply_divide_hi_lo_unit_tb.sv -----
`timescale 1ns / 1ps

module multiply_divide_hi_lo_unit_tb;
	import mdhl_pkg::*;

	localparam logic [WordW-1:0] MIN_WORD    = 32'h8000_0000;
	localparam logic [WordW-1:0] MAX_WORD    = 32'h7FFF_FFFF;
	localparam logic [WordW-1:0] NEG_ONE     = 32'hFFFF_FFFF;
	localparam int               RAND_BEATS  = 1550;
	localparam int               HOLD_CYCLES = 400;
	localparam int               DRAIN_WAIT  = 60;
	localparam int               CYCLE_LIMIT = 1_500_000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        op = OP_MFLO;
	logic [WordW-1:0]  rs_value = '0;
	logic [WordW-1:0]  rt_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DwordW-1:0] rd_value;
	logic              rd_write;

	int error_count;
	int pending_count;
	int checked_count;

	logic calm = 1'b0;
	int   hold_requests = 0;
	int   issued[8] = '{default: 0};
	int   zero_divs = 0;
	int   overflows = 0;
	int   cycle_count = 0;

	multiply_divide_hi_lo_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.rs_value  (rs_value),
		.rt_value  (rt_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rd_value  (rd_value),
		.rd_write  (rd_write)
	);

	mdhl_rd_checker rd_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.rs_value      (rs_value),
		.rt_value      (rt_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.rd_value      (rd_value),
		.rd_write      (rd_write),
		.error_count   (error_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d rd beats outstanding",
				$time, cycle_count, pending_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [WordW-1:0] pick_word();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 32'd1;
			2: return NEG_ONE;
			3: return MIN_WORD;
			4: return MAX_WORD;
			5: return WordW'($urandom_range(0, 255));
			6: return -WordW'($urandom_range(1, 255));
			default: return $urandom();
		endcase
	endfunction

	// drive one beat, wait for it to be taken, then maybe idle
	task automatic send_beat(input op_t code, input logic [WordW-1:0] a,
			input logic [WordW-1:0] b);
		int gap;
		int roll;
		in_valid <= 1'b1;
		op <= code;
		rs_value <= a;
		rt_value <= b;
		do @(posedge clk); while (in_stall);
		issued[int'(code)]++;
		if (b == '0 && (code == OP_DIV || code == OP_DIVU || code == OP_DIVU1))
			zero_divs++;
		if (code == OP_DIV && a == MIN_WORD && b == NEG_ONE)
			overflows++;
		gap = 0;
		if (!calm) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				gap = 0;
			else if (roll < 85)
				gap = $urandom_range(1, 4);
			else if (roll < 97)
				gap = $urandom_range(5, 40);
			else
				gap = $urandom_range(41, 120);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// output side backpressure
	initial begin
		int served;
		int len;
		int roll;
		served = 0;
		@(posedge clk);
		forever begin
			if (hold_requests > served) begin
				served++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					out_stall <= 1'b0;
					len = $urandom_range(1, 8);
				end else if (roll < 92) begin
					out_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					len = $urandom_range(20, 80);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin
		op_t              code;
		logic [WordW-1:0] a, b;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset contents, then extremes and corner cases of each instruction
		send_beat(OP_MFLO, '0, '0);
		send_beat(OP_MFHI, NEG_ONE, NEG_ONE);
		send_beat(OP_MFLO1, '0, '0);
		send_beat(OP_MULT, MIN_WORD, MIN_WORD);
		send_beat(OP_MFHI, '0, '0);
		send_beat(OP_MULT, NEG_ONE, NEG_ONE);
		send_beat(OP_MULT, MAX_WORD, MIN_WORD);
		send_beat(OP_DIV, 32'd7, '0);
		send_beat(OP_MFLO, '0, '0);
		send_beat(OP_MFHI, '0, '0);
		send_beat(OP_DIV, 32'h8000_0005, '0);
		send_beat(OP_MFLO, '0, '0);
		send_beat(OP_DIV, MIN_WORD, NEG_ONE);
		send_beat(OP_MFLO, '0, '0);
		send_beat(OP_MFHI, '0, '0);
		send_beat(OP_DIV, -32'd7, 32'd2);
		send_beat(OP_MFHI, '0, '0);
		send_beat(OP_DIVU, NEG_ONE, '0);
		send_beat(OP_MFLO, '0, '0);
		send_beat(OP_MULT1, NEG_ONE, MIN_WORD);
		send_beat(OP_MFLO1, '0, '0);
		send_beat(OP_DIVU1, 32'hFFFF_FFFE, '0);
		send_beat(OP_MFLO1, '0, '0);
		send_beat(OP_DIVU1, NEG_ONE, 32'd3);
		send_beat(OP_MFLO1, '0, '0);
		send_beat(OP_MFHI, '0, '0);

		for (int i = 0; i < RAND_BEATS; i++) begin
			calm <= ((i / 150) % 5 == 2);
			code = op_t'($urandom_range(0, 7));
			a = pick_word();
			b = pick_word();
			if (code == OP_DIV && $urandom_range(0, 15) == 0) begin
				a = MIN_WORD;
				b = NEG_ONE;
			end
			if ((code == OP_DIV || code == OP_DIVU || code == OP_DIVU1)
					&& $urandom_range(0, 9) == 0)
				b = '0;
			// long output hold while beats keep coming
			if (i == 500)
				hold_requests++;
			send_beat(code, a, b);
			// drain fully once before resuming
			if (i == 1000) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_count != 0);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d beats: mult %0d div %0d divu %0d mflo %0d mfhi %0d mult1 %0d divu1 %0d mflo1 %0d",
			issued.sum(), issued[OP_MULT], issued[OP_DIV], issued[OP_DIVU],
			issued[OP_MFLO], issued[OP_MFHI], issued[OP_MULT1], issued[OP_DIVU1],
			issued[OP_MFLO1]);
		$display("Compared %0d rd beats, %0d divides by zero, %0d signed overflows, one long hold",
			checked_count, zero_divs, overflows);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mdhl_pkg.sv
rtl/core/mdhl_core.sv
rtl/core/multiply_divide_hi_lo_unit.sv
rtl/core/mdhl_checker.sv
dv/mdhl_rd_checker.sv
dv/multiply_divide_hi_lo_unit_tb.sv
